### src/quadratic_root_solver_core_macros.svh
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define QRS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define QRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### src/qrs_pkg.sv
package qrs_pkg;

    localparam int ROOT_W  = 32;
    localparam int COUNT_W = 2;

    localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
    localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
    localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;

    typedef enum logic [1:0] {
        CLS_DEGEN,
        CLS_NONE,
        CLS_DOUBLE,
        CLS_TWO
    } t_disc_class;

endpackage

### src/qrs_coef_if.sv
interface qrs_coef_if #(
    parameter int COEF_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COEF_WIDTH-1:0] coef_square;
    logic signed [COEF_WIDTH-1:0] coef_linear;
    logic signed [COEF_WIDTH-1:0] coef_const;

    modport source (output valid, output coef_square, output coef_linear,
                    output coef_const, input ready);
    modport sink   (input valid, input coef_square, input coef_linear,
                    input coef_const, output ready);
endinterface

### src/qrs_root_if.sv
interface qrs_root_if
    import qrs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [COUNT_W-1:0]       root_count;
    logic signed [ROOT_W-1:0] first_root;
    logic signed [ROOT_W-1:0] second_root;
    logic                     degenerate;
    logic                     saturated;

    modport source (output valid, output root_count, output first_root,
                    output second_root, output degenerate, output saturated,
                    input ready);
    modport sink   (input valid, input root_count, input first_root,
                    input second_root, input degenerate, input saturated,
                    output ready);
endinterface

### src/quadratic_root_solver_core.sv
// Throughput: one beat per cycle while the output is not stalled.
// Stages: products, discriminant, one root bit per sqrt stage, numerators,
// one quotient bit per divider stage (both roots in parallel lanes), clip/output.
// A stalled output beat freezes the whole pipe; input ready follows the output register.
// Synchronous active-low reset clears valid bits, input ready low; payload not reset.
module quadratic_root_solver_core
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH     = 16,
    parameter int ROOT_FRAC_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qrs_coef_if.sink       i_coef,
    qrs_root_if.source     o_root
);

`include "quadratic_root_solver_core_macros.svh"

    localparam int CW   = COEF_WIDTH;
    localparam int F    = ROOT_FRAC_BITS;
    localparam int PW   = 2 * CW;
    localparam int DSW  = 2 * CW + 3;
    localparam int DW   = 2 * CW + 1;
    localparam int SW   = CW + F + 1;
    localparam int RADW = 2 * SW;
    localparam int SRW  = SW + 3;
    localparam int NMW  = CW + F + 1;
    localparam int NW   = NMW + 1;
    localparam int DVW  = CW + 1;
    localparam int QW   = (NMW > ROOT_W + 1) ? NMW : ROOT_W + 1;

    localparam logic [QW-1:0] Q_NEG_LIM = QW'(64'h8000_0000);
    localparam logic [QW-1:0] Q_POS_LIM = QW'(64'h7FFF_FFFF);

    typedef struct packed {
        t_disc_class           cls;
        logic                  a_neg;
        logic [CW-1:0]         a_mag;
        logic signed [NMW-1:0] nb;
    } t_side;

    logic w_adv;

    // ---------------- stage 1: products
    logic                  r_s1_valid;
    logic signed [PW-1:0]  r_s1_bb, r_s1_ac;
    logic                  r_s1_a_zero, r_s1_a_neg;
    logic [CW-1:0]         r_s1_a_mag;
    logic signed [NMW-1:0] r_s1_nb;

    logic [CW:0]           n_s1_a_abs;
    logic signed [NMW-1:0] n_s1_nb;

    always_comb begin
        n_s1_a_abs = i_coef.coef_square[CW-1]
                   ? (CW+1)'(0) - {i_coef.coef_square[CW-1], i_coef.coef_square}
                   : {1'b0, i_coef.coef_square};
        n_s1_nb    = (NMW)'(0) - ($signed({{(NMW-CW){i_coef.coef_linear[CW-1]}},
                                           i_coef.coef_linear}) <<< F);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_coef.valid;
        end
        if (w_adv) begin
            r_s1_bb     <= i_coef.coef_linear * i_coef.coef_linear;
            r_s1_ac     <= i_coef.coef_square * i_coef.coef_const;
            r_s1_a_zero <= (i_coef.coef_square == '0);
            r_s1_a_neg  <= i_coef.coef_square[CW-1];
            r_s1_a_mag  <= n_s1_a_abs[CW-1:0];
            r_s1_nb     <= n_s1_nb;
        end
    end

    // ---------------- stage 2: discriminant and class
    logic                  r_sq_valid [0:SW];
    t_side                 r_sq_side  [0:SW];
    logic [RADW-1:0]       r_sq_rad   [0:SW];
    logic [SRW-1:0]        r_sq_rem   [0:SW];
    logic [SW-1:0]         r_sq_root  [0:SW];

    logic signed [DSW-1:0] n_s2_d;
    t_disc_class           n_s2_cls;
    logic [RADW-1:0]       n_s2_rad;

    always_comb begin
        n_s2_d = $signed({{(DSW-PW){r_s1_bb[PW-1]}}, r_s1_bb})
               - ($signed({{(DSW-PW){r_s1_ac[PW-1]}}, r_s1_ac}) <<< 2);
        if (r_s1_a_zero)          n_s2_cls = CLS_DEGEN;
        else if (n_s2_d[DSW-1])   n_s2_cls = CLS_NONE;
        else if (n_s2_d == '0)    n_s2_cls = CLS_DOUBLE;
        else                      n_s2_cls = CLS_TWO;
        n_s2_rad = (n_s2_cls == CLS_TWO)
                 ? ((RADW)'(n_s2_d[DW-1:0]) << (2 * F)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_sq_valid[0] <= r_s1_valid;
        end
        if (w_adv) begin
            r_sq_side[0] <= '{cls: n_s2_cls, a_neg: r_s1_a_neg,
                              a_mag: r_s1_a_mag, nb: r_s1_nb};
            r_sq_rad[0]  <= n_s2_rad;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    // ---------------- sqrt: one root bit per stage
    for (genvar k = 0; k < SW; k++) begin : g_sqrt
        logic [SRW-1:0] n_rem_sh, n_trial;
        logic           n_ge;

        always_comb begin
            n_rem_sh = {r_sq_rem[k][SRW-3:0], r_sq_rad[k][RADW-1 -: 2]};
            n_trial  = {1'b0, r_sq_root[k], 2'b01};
            n_ge     = (n_rem_sh >= n_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_valid[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_sq_valid[k+1] <= r_sq_valid[k];
            end
            if (w_adv) begin
                r_sq_side[k+1] <= r_sq_side[k];
                r_sq_rad[k+1]  <= r_sq_rad[k] << 2;
                r_sq_rem[k+1]  <= n_ge ? n_rem_sh - n_trial : n_rem_sh;
                r_sq_root[k+1] <= {r_sq_root[k][SW-2:0], n_ge};
            end
        end
    end

    // ---------------- numerators
    logic               r_dv_valid [0:NMW];
    t_disc_class        r_dv_cls   [0:NMW];
    logic [DVW-1:0]     r_dv_div   [0:NMW];
    logic [1:0]         r_dv_neg   [0:NMW];
    logic [NMW-1:0]     r_dv_num   [0:NMW][2];
    logic [DVW-1:0]     r_dv_rem   [0:NMW][2];
    logic [NMW-1:0]     r_dv_quo   [0:NMW][2];

    t_side              w_nm_side;
    logic signed [NW-1:0] n_nm_n [2];
    logic [NW-1:0]      n_nm_mag [2];

    always_comb begin
        w_nm_side = r_sq_side[SW];
        n_nm_n[0] = $signed({w_nm_side.nb[NMW-1], w_nm_side.nb})
                  - $signed({1'b0, r_sq_root[SW]});
        n_nm_n[1] = $signed({w_nm_side.nb[NMW-1], w_nm_side.nb})
                  + $signed({1'b0, r_sq_root[SW]});
        for (int l = 0; l < 2; l++) begin
            n_nm_mag[l] = n_nm_n[l][NW-1] ? NW'(0) - n_nm_n[l] : n_nm_n[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_valid[0] <= 1'b0;
        end else if (w_adv) begin
            r_dv_valid[0] <= r_sq_valid[SW];
        end
        if (w_adv) begin
            r_dv_cls[0] <= w_nm_side.cls;
            r_dv_div[0] <= {w_nm_side.a_mag, 1'b0};
            r_dv_neg[0] <= {n_nm_n[1][NW-1] ^ w_nm_side.a_neg,
                            n_nm_n[0][NW-1] ^ w_nm_side.a_neg};
            for (int l = 0; l < 2; l++) begin
                r_dv_num[0][l] <= n_nm_mag[l][NMW-1:0];
                r_dv_rem[0][l] <= '0;
                r_dv_quo[0][l] <= '0;
            end
        end
    end

    // ---------------- dividers: one quotient bit per stage, two lanes
    for (genvar k = 0; k < NMW; k++) begin : g_div
        logic [DVW:0] n_rem_sh [2];
        logic [1:0]   n_ge;

        always_comb begin
            for (int l = 0; l < 2; l++) begin
                n_rem_sh[l] = {r_dv_rem[k][l], r_dv_num[k][l][NMW-1]};
                n_ge[l]     = (n_rem_sh[l] >= {1'b0, r_dv_div[k]});
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_valid[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv_valid[k+1] <= r_dv_valid[k];
            end
            if (w_adv) begin
                r_dv_cls[k+1] <= r_dv_cls[k];
                r_dv_div[k+1] <= r_dv_div[k];
                r_dv_neg[k+1] <= r_dv_neg[k];
                for (int l = 0; l < 2; l++) begin
                    r_dv_num[k+1][l] <= r_dv_num[k][l] << 1;
                    r_dv_rem[k+1][l] <= n_ge[l]
                                      ? DVW'(n_rem_sh[l] - {1'b0, r_dv_div[k]})
                                      : n_rem_sh[l][DVW-1:0];
                    r_dv_quo[k+1][l] <= {r_dv_quo[k][l][NMW-2:0], n_ge[l]};
                end
            end
        end
    end

    // ---------------- clip and output register
    logic                     r_out_valid;
    logic [COUNT_W-1:0]       r_out_count;
    logic signed [ROOT_W-1:0] r_out_r1, r_out_r2;
    logic                     r_out_degen, r_out_sat;

    logic [QW-1:0]            n_q    [2];
    logic [ROOT_W-1:0]        n_clip [2];
    logic [1:0]               n_csat;
    logic [COUNT_W-1:0]       n_count;
    logic [ROOT_W-1:0]        n_r1, n_r2;
    logic                     n_sat;

    assign w_adv        = !r_out_valid || o_root.ready;
    assign i_coef.ready = w_adv && i_rst_n;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_q[l]    = QW'(r_dv_quo[NMW][l]);
            n_csat[l] = 1'b0;
            if (r_dv_neg[NMW][l]) begin
                if (n_q[l] > Q_NEG_LIM) begin
                    n_csat[l] = 1'b1;
                    n_clip[l] = ROOT_W'(Q_NEG_LIM);
                end else begin
                    n_clip[l] = ROOT_W'(0) - n_q[l][ROOT_W-1:0];
                end
            end else begin
                if (n_q[l] > Q_POS_LIM) begin
                    n_csat[l] = 1'b1;
                    n_clip[l] = ROOT_W'(Q_POS_LIM);
                end else begin
                    n_clip[l] = n_q[l][ROOT_W-1:0];
                end
            end
        end
        case (r_dv_cls[NMW])
            CLS_DOUBLE: begin
                n_count = CNT_ONE;
                n_r1    = n_clip[0];
                n_r2    = '0;
                n_sat   = n_csat[0];
            end
            CLS_TWO: begin
                n_count = CNT_TWO;
                n_r1    = n_clip[0];
                n_r2    = n_clip[1];
                n_sat   = n_csat[0] | n_csat[1];
            end
            default: begin
                n_count = CNT_NONE;
                n_r1    = '0;
                n_r2    = '0;
                n_sat   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_dv_valid[NMW];
        end
        if (w_adv) begin
            r_out_count <= n_count;
            r_out_r1    <= n_r1;
            r_out_r2    <= n_r2;
            r_out_degen <= (r_dv_cls[NMW] == CLS_DEGEN);
            r_out_sat   <= n_sat;
        end
    end

    assign o_root.valid       = r_out_valid;
    assign o_root.root_count  = r_out_count;
    assign o_root.first_root  = r_out_r1;
    assign o_root.second_root = r_out_r2;
    assign o_root.degenerate  = r_out_degen;
    assign o_root.saturated   = r_out_sat;

    `QRS_ASSERT_NOW(a_degen_no_roots, i_clk, i_rst_n, o_root.valid && o_root.degenerate, o_root.root_count == CNT_NONE && o_root.first_root == '0 && o_root.second_root == '0, "degenerate beat carries roots")
    `QRS_ASSERT_NOW(a_second_unused_zero, i_clk, i_rst_n, o_root.valid && o_root.root_count != CNT_TWO, o_root.second_root == '0, "unused second root not zero")
    `QRS_ASSERT_NOW(a_sat_needs_root, i_clk, i_rst_n, o_root.valid && o_root.saturated, o_root.root_count != CNT_NONE && !o_root.degenerate, "saturation flagged without a root")
    `QRS_ASSERT_NEXT(a_stall_freezes, i_clk, i_rst_n, r_dv_valid[NMW] && o_root.valid && !o_root.ready, r_dv_valid[NMW] && o_root.valid, "pipe moved during output stall")

endmodule
